// ----- src/faeg_pkg.sv -----
// shared types, constants and register codes of the frame auto exposure / gain unit
// no dependencies; used by the channel interfaces and every module in src

package faeg_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 4'd0,
		REG_TARGET     = 4'd1,
		REG_WINDOW     = 4'd2,
		REG_STEP_SHIFT = 4'd3
	} faeg_reg_t;

	// register reset values
	localparam logic       RST_ENABLE     = 1'b1;
	localparam logic [7:0] RST_TARGET     = 8'd110;
	localparam logic [6:0] RST_WINDOW     = 7'd20;
	localparam logic [2:0] RST_STEP_SHIFT = 3'd4;

	// frame decimation
	localparam logic [3:0] FRAME_INTERVAL = 4'd13;

	// luma weights, sum of 8-bit means fits 16 bits
	localparam logic [15:0] LUMA_R_WT = 16'd77;
	localparam logic [15:0] LUMA_G_WT = 16'd75;
	localparam logic [15:0] LUMA_B_WT = 16'd29;

	// divide by 50 for |err| <= 255: (x * 41) >> 11
	localparam logic [5:0] GAIN_RECIP       = 6'd41;
	localparam int unsigned GAIN_RECIP_SHIFT = 11;

	// clamp limits
	localparam logic signed [17:0] GAIN_CLAMP_LO = 18'sd3;
	localparam logic signed [17:0] GAIN_CLAMP_HI = 18'sd63;
	localparam logic signed [12:0] EXPO_MIN = 13'sd3;
	localparam logic signed [12:0] EXPO_MAX = 13'sd598;
	localparam logic [10:0] EXPO_MASK  = 11'h7ff;
	localparam logic [11:0] PIXCLK_BIT = 12'h800;

	// live register settings handed to the datapath
	typedef struct packed {
		logic       enable;
		logic [7:0] target;
		logic [6:0] window;
		logic [2:0] step_shift;
	} faeg_cfg_t;

endpackage

// ----- src/faeg_if.sv -----
// valid/ready channel interfaces of the frame auto exposure / gain unit
// depends on faeg_pkg

interface faeg_in_if import faeg_pkg::*; ;
	logic        valid;
	logic        ready;
	logic [7:0]  red_mean;
	logic [7:0]  green_red_mean;
	logic [7:0]  green_blue_mean;
	logic [7:0]  blue_mean;
	logic [15:0] sensor_exposure;
	logic [15:0] sensor_gain;
	logic        exposure_read_failed;
	logic        gain_read_failed;

	modport source (
		output valid, red_mean, green_red_mean, green_blue_mean, blue_mean,
		output sensor_exposure, sensor_gain, exposure_read_failed, gain_read_failed,
		input  ready
	);
	modport sink (
		input  valid, red_mean, green_red_mean, green_blue_mean, blue_mean,
		input  sensor_exposure, sensor_gain, exposure_read_failed, gain_read_failed,
		output ready
	);
endinterface

interface faeg_out_if import faeg_pkg::*; ;
	logic        valid;
	logic        ready;
	logic [5:0]  new_gain;
	logic [11:0] exposure_word;

	modport source (output valid, new_gain, exposure_word, input ready);
	modport sink (input valid, new_gain, exposure_word, output ready);
endinterface

interface faeg_cfg_if import faeg_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/faeg_regs.sv -----
// configuration registers and frame countdown
// depends on faeg_pkg and faeg_cfg_if

module faeg_regs import faeg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	faeg_cfg_if.sink         cfg,
	input  logic             frame_take,
	output faeg_cfg_t        settings,
	output logic             act,
	output logic [3:0]       countdown
);

	faeg_cfg_t  settings_q;
	logic [3:0] countdown_q;
	logic       cfg_take;

	assign cfg.ready = 1'b1;
	assign cfg_take  = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q.enable     <= RST_ENABLE;
			settings_q.target     <= RST_TARGET;
			settings_q.window     <= RST_WINDOW;
			settings_q.step_shift <= RST_STEP_SHIFT;
		end else if (cfg_take) begin
			case (cfg.index)
				REG_ENABLE:     settings_q.enable     <= cfg.data[0];
				REG_TARGET:     settings_q.target     <= cfg.data[7:0];
				REG_WINDOW:     settings_q.window     <= cfg.data[6:0];
				REG_STEP_SHIFT: settings_q.step_shift <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// countdown reloads on an enable write, steps once per frame while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= FRAME_INTERVAL;
		end else if (cfg_take && cfg.index == REG_ENABLE) begin
			countdown_q <= FRAME_INTERVAL;
		end else if (frame_take && settings_q.enable) begin
			if (countdown_q == 4'd0) begin
				countdown_q <= FRAME_INTERVAL;
			end else begin
				countdown_q <= countdown_q - 4'd1;
			end
		end
	end

	assign settings  = settings_q;
	assign act       = settings_q.enable && (countdown_q == 4'd0);
	assign countdown = countdown_q;

endmodule

// ----- src/faeg_dp.sv -----
// two-stage regulator datapath: luma/input register, then error, step and clamp
// depends on faeg_pkg, faeg_in_if and faeg_out_if

module faeg_dp import faeg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	faeg_in_if.sink    frame,
	faeg_out_if.source result,
	input  faeg_cfg_t  settings,
	input  logic       act
);

	logic [15:0]        luma_sum;
	logic               frame_take;

	logic               valid_s1;
	logic               act_s1;
	logic [7:0]         luma_s1;
	logic [10:0]        expo_s1;
	logic signed [16:0] gain_s1;

	logic signed [9:0]  err;
	logic signed [9:0]  win;
	logic               in_band;
	logic               emit_s1;
	logic signed [9:0]  expo_step;
	logic signed [12:0] expo_sum;
	logic [10:0]        expo_new;
	logic [7:0]         err_mag;
	logic [13:0]        div_prod;
	logic [2:0]         div_q;
	logic signed [3:0]  gain_step;
	logic signed [17:0] gain_sum;
	logic [5:0]         gain_new;

	logic               out_valid_q;
	logic [5:0]         new_gain_q;
	logic [11:0]        exposure_word_q;
	logic               out_free;
	logic               s1_adv;

	// stage 1: luma and sensor words with failed reads folded in
	assign luma_sum = LUMA_R_WT * 16'(frame.red_mean)
		+ LUMA_G_WT * (16'(frame.green_red_mean) + 16'(frame.green_blue_mean))
		+ LUMA_B_WT * 16'(frame.blue_mean);

	assign out_free    = !out_valid_q || result.ready;
	assign s1_adv      = !emit_s1 || out_free;
	assign frame.ready = !valid_s1 || s1_adv;
	assign frame_take  = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			act_s1   <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
			act_s1   <= act;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			luma_s1 <= luma_sum[15:8];
			expo_s1 <= frame.exposure_read_failed ? EXPO_MASK
				: (frame.sensor_exposure[10:0] & EXPO_MASK);
			gain_s1 <= frame.gain_read_failed ? -17'sd1
				: $signed({1'b0, frame.sensor_gain});
		end
	end

	// stage 2: dead band, steps and clamps
	assign err     = $signed({2'b00, settings.target}) - $signed({2'b00, luma_s1});
	assign win     = $signed({3'b000, settings.window});
	assign in_band = (err >= -win) && (err <= win);
	assign emit_s1 = valid_s1 && act_s1 && !in_band;

	assign expo_step = err >>> settings.step_shift;
	assign expo_sum  = $signed({2'b00, expo_s1}) + {{3{expo_step[9]}}, expo_step};

	always_comb begin
		if (expo_sum > EXPO_MAX) begin
			expo_new = 11'(EXPO_MAX);
		end else if (expo_sum < EXPO_MIN) begin
			expo_new = 11'(EXPO_MIN);
		end else begin
			expo_new = expo_sum[10:0];
		end
	end

	// truncating divide by 50 on the magnitude, sign restored after
	assign err_mag   = err[9] ? 8'(-err) : err[7:0];
	assign div_prod  = 14'(err_mag) * 14'(GAIN_RECIP);
	assign div_q     = div_prod[13:GAIN_RECIP_SHIFT];
	assign gain_step = err[9] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
	assign gain_sum  = {gain_s1[16], gain_s1} + {{14{gain_step[3]}}, gain_step};

	always_comb begin
		if (gain_sum > GAIN_CLAMP_HI) begin
			gain_new = 6'(GAIN_CLAMP_HI);
		end else if (gain_sum < GAIN_CLAMP_LO) begin
			gain_new = 6'(GAIN_CLAMP_LO);
		end else begin
			gain_new = gain_sum[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_s1) begin
			new_gain_q      <= gain_new;
			exposure_word_q <= PIXCLK_BIT | {1'b0, expo_new};
		end
	end

	assign result.valid         = out_valid_q;
	assign result.new_gain      = new_gain_q;
	assign result.exposure_word = exposure_word_q;

endmodule

// ----- src/frame_auto_exposure_gain_unit.sv -----
// top level of the frame auto exposure / gain regulator
// depends on faeg_pkg, faeg_if (channels), faeg_regs and faeg_dp

// One request on frame carries the statistics of one finished frame: four color means and
// the sensor's current exposure and gain words. While enabled, the regulator acts on one
// frame out of every fourteen; on that frame it forms luma, and if luma falls outside
// target +- window it steps exposure by the shifted error and gain by the error over 50,
// clamps both and sends one request on result (gain 3..63, exposure 3..598 with bit 0x800
// set). Other frames, and all frames while disabled, produce nothing. A new frame is taken
// every cycle save when frame stalls: an input register and a result register part the two
// sides, and frame only stalls when a finished result waits on result while another
// emitting frame sits in the input register. The cfg channel is always ready; index 0
// enable (writing it restarts the frame count), 1 luma target, 2 window half width,
// 3 exposure step shift; other indexes are dropped.

module frame_auto_exposure_gain_unit import faeg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	faeg_in_if.sink    frame,
	faeg_out_if.source result,
	faeg_cfg_if.sink   cfg
);

	faeg_cfg_t  settings;
	logic       act;
	logic [3:0] countdown;
	logic       frame_take;

	// frame request accepted this cycle
	assign frame_take = frame.valid & frame.ready;

	// registers plus the decimating frame counter
	faeg_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.frame_take (frame_take),
		.settings   (settings),
		.act        (act),
		.countdown  (countdown)
	);

	// luma, error, steps and clamps
	faeg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.result   (result),
		.settings (settings),
		.act      (act)
	);

`ifndef SYNTH
	// a delivered result is always inside the clamp limits with the pixel clock bit set
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.new_gain >= 6'd3) && result.exposure_word[11]
			&& (result.exposure_word[10:0] >= 11'd3)
			&& (result.exposure_word[10:0] <= 11'd598))
		else $error("result outside clamp limits");

	// the frame count never leaves its reload range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		countdown <= FRAME_INTERVAL)
		else $error("frame countdown out of range");

	// an acting frame reloads the count
	a_act_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_take && act) |=> (countdown == FRAME_INTERVAL))
		else $error("frame countdown not reloaded after acting frame");

	// while disabled a frame leaves the count alone
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_take && !settings.enable && !(cfg.valid && cfg.ready)) |=> $stable(countdown))
		else $error("frame countdown moved while disabled");
`endif

endmodule
